FILE: rtl/core/bpor_pkg.sv
// ----------------------------------------------------------------------------
// bpor_pkg
// Shared constants for the box pair overlap ratio pipeline.
// ----------------------------------------------------------------------------
package bpor_pkg;

    localparam int COORD_BITS_DEF      = 20;
    localparam int RATIO_FRAC_BITS_DEF = 15;
    localparam int MARGIN_W            = 8;
    localparam int RATIO_W             = RATIO_FRAC_BITS_DEF + 1;
    localparam int OUT_BITS            = 2 * RATIO_W + 1;
    localparam int OUT_W               = ((OUT_BITS + 7) / 8) * 8;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    // Register indexes
    localparam logic REG_EXTENT_MARGIN = 1'b0;

endpackage

FILE: rtl/core/bpor_extent.sv
// ----------------------------------------------------------------------------
// bpor_extent
// Two stages: corner min/max and box extents, then overlap extents and flag.
// ----------------------------------------------------------------------------
module bpor_extent
    import bpor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [8*COORD_BITS-1:0] i_coords,
    input  logic [MARGIN_W-1:0]   i_margin,
    output logic                  o_vld,
    output logic                  o_ovl,
    output logic [COORD_BITS:0]   o_iw,
    output logic [COORD_BITS:0]   o_ih,
    output logic [COORD_BITS:0]   o_bw,
    output logic [COORD_BITS:0]   o_bh,
    output logic [COORD_BITS:0]   o_qw,
    output logic [COORD_BITS:0]   o_qh
);
    localparam int SW = COORD_BITS + 2;

    logic signed [SW-1:0] c [8];
    logic signed [SW-1:0] m;
    logic signed [SW-1:0] r_xlo, r_xhi, r_ylo, r_yhi, r_bw, r_bh, r_qw, r_qh;
    logic signed [SW-1:0] iw, ih;
    logic                 r_vld1, r_vld2, r_ovl;
    logic [COORD_BITS:0]  r_iw, r_ih, r_bw2, r_bh2, r_qw2, r_qh2;

    // Sign-extend the eight corners
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c[k] = SW'($signed(i_coords[k*COORD_BITS +: COORD_BITS]));
        end
        m = $signed({{(SW-MARGIN_W){1'b0}}, i_margin});
    end

    // Stage one: overlap bounds and widened box extents
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xlo <= (c[0] > c[4]) ? c[0] : c[4];
            r_ylo <= (c[1] > c[5]) ? c[1] : c[5];
            r_xhi <= (c[2] < c[6]) ? c[2] : c[6];
            r_yhi <= (c[3] < c[7]) ? c[3] : c[7];
            r_bw  <= c[2] - c[0] + m;
            r_bh  <= c[3] - c[1] + m;
            r_qw  <= c[6] - c[4] + m;
            r_qh  <= c[7] - c[5] + m;
        end
    end

    assign iw = r_xhi - r_xlo + m;
    assign ih = r_yhi - r_ylo + m;

    // Stage two: overlap extents and flag
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovl <= (iw > 0) && (ih > 0);
            r_iw  <= iw[COORD_BITS:0];
            r_ih  <= ih[COORD_BITS:0];
            r_bw2 <= r_bw[COORD_BITS:0];
            r_bh2 <= r_bh[COORD_BITS:0];
            r_qw2 <= r_qw[COORD_BITS:0];
            r_qh2 <= r_qh[COORD_BITS:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_ovl = r_ovl;
    assign o_iw  = r_iw;
    assign o_ih  = r_ih;
    assign o_bw  = r_bw2;
    assign o_bh  = r_bh2;
    assign o_qw  = r_qw2;
    assign o_qh  = r_qh2;
endmodule

FILE: rtl/core/bpor_area.sv
// ----------------------------------------------------------------------------
// bpor_area
// Two stages: the three area products, then the union area.
// ----------------------------------------------------------------------------
module bpor_area
    import bpor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic                      i_ovl,
    input  logic [COORD_BITS:0]       i_iw,
    input  logic [COORD_BITS:0]       i_ih,
    input  logic [COORD_BITS:0]       i_bw,
    input  logic [COORD_BITS:0]       i_bh,
    input  logic [COORD_BITS:0]       i_qw,
    input  logic [COORD_BITS:0]       i_qh,
    output logic                      o_vld,
    output logic                      o_ovl,
    output logic [2*COORD_BITS+1:0]   o_inter,
    output logic [2*COORD_BITS+1:0]   o_qarea,
    output logic [2*COORD_BITS+2:0]   o_union
);
    localparam int PW = 2 * (COORD_BITS + 1);

    logic [PW-1:0] r_inter, r_barea, r_qarea, r_inter2, r_qarea2;
    logic [PW:0]   r_union;
    logic          r_vld1, r_vld2, r_ovl1, r_ovl2;

    // Stage three: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inter <= i_iw * i_ih;
            r_barea <= i_bw * i_bh;
            r_qarea <= i_qw * i_qh;
            r_ovl1  <= i_ovl;
        end
    end

    // Stage four: union
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_union  <= {1'b0, r_barea} + {1'b0, r_qarea} - {1'b0, r_inter};
            r_inter2 <= r_inter;
            r_qarea2 <= r_qarea;
            r_ovl2   <= r_ovl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld   = r_vld2;
    assign o_ovl   = r_ovl2;
    assign o_inter = r_inter2;
    assign o_qarea = r_qarea2;
    assign o_union = r_union;
endmodule

FILE: rtl/core/bpor_divider.sv
// ----------------------------------------------------------------------------
// bpor_divider
// Restoring fraction divider, one quotient bit per stage, two lanes:
// intersection over union and intersection over query area.
// ----------------------------------------------------------------------------
module bpor_divider
    import bpor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic                      i_ovl,
    input  logic [2*COORD_BITS+1:0]   i_inter,
    input  logic [2*COORD_BITS+1:0]   i_qarea,
    input  logic [2*COORD_BITS+2:0]   i_union,
    output logic                      o_vld,
    output logic                      o_ovl,
    output logic [RATIO_W-1:0]        o_union_ratio,
    output logic [RATIO_W-1:0]        o_query_ratio
);
    localparam int PW = 2 * (COORD_BITS + 1);
    localparam int RW = PW + 2;
    localparam int QN = RATIO_W;

    logic [RW-1:0] r_ru [QN];
    logic [RW-1:0] r_rq [QN];
    logic [RW-1:0] r_du [QN];
    logic [RW-1:0] r_dq [QN];
    logic [QN-1:0] r_qu [QN];
    logic [QN-1:0] r_qq [QN];
    logic [QN-1:0] r_vld;
    logic [QN-1:0] r_ovl;

    genvar k;
    generate
        for (k = 0; k < QN; k++) begin : g_step
            logic [RW-1:0] ru_in, rq_in, du_in, dq_in;
            logic [QN-1:0] qu_in, qq_in;
            logic          vld_in, ovl_in, ge_u, ge_q;

            // Pick the partial remainder: numerator first, doubled afterwards
            if (k == 0) begin : g_first
                assign ru_in  = {2'b00, i_inter};
                assign rq_in  = {2'b00, i_inter};
                assign du_in  = {1'b0, i_union};
                assign dq_in  = {2'b00, i_qarea};
                assign qu_in  = '0;
                assign qq_in  = '0;
                assign vld_in = i_vld;
                assign ovl_in = i_ovl;
            end else begin : g_next
                assign ru_in  = {r_ru[k-1][RW-2:0], 1'b0};
                assign rq_in  = {r_rq[k-1][RW-2:0], 1'b0};
                assign du_in  = r_du[k-1];
                assign dq_in  = r_dq[k-1];
                assign qu_in  = r_qu[k-1];
                assign qq_in  = r_qq[k-1];
                assign vld_in = r_vld[k-1];
                assign ovl_in = r_ovl[k-1];
            end

            assign ge_u = ru_in >= du_in;
            assign ge_q = rq_in >= dq_in;

            // Compare, subtract, shift in one quotient bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ru[k]  <= ge_u ? ru_in - du_in : ru_in;
                    r_rq[k]  <= ge_q ? rq_in - dq_in : rq_in;
                    r_du[k]  <= du_in;
                    r_dq[k]  <= dq_in;
                    r_qu[k]  <= {qu_in[QN-2:0], ge_u};
                    r_qq[k]  <= {qq_in[QN-2:0], ge_q};
                    r_ovl[k] <= ovl_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vld_in;
                end
            end
        end
    endgenerate

    // Zero both ratios when the boxes do not overlap
    assign o_vld         = r_vld[QN-1];
    assign o_ovl         = r_ovl[QN-1];
    assign o_union_ratio = r_ovl[QN-1] ? r_qu[QN-1] : '0;
    assign o_query_ratio = r_ovl[QN-1] ? r_qq[QN-1] : '0;
endmodule

FILE: rtl/core/box_pair_overlap_ratios.sv
// ----------------------------------------------------------------------------
// box_pair_overlap_ratios
// Overlap ratios (IoU and intersection over query area) of one box pair.
// ----------------------------------------------------------------------------
// Takes one box pair per cycle unless a result waits untaken at the output,
// and returns one result per pair, in order. The pipeline is two extent
// stages, a product stage, a union stage, then one restoring divider stage
// per quotient bit. The whole pipeline holds while the result at the output
// is not taken; s_axis_tready drops only then. extent_margin sits at byte
// address 0 and must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module box_pair_overlap_ratios
    import bpor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    // box_x_min, box_y_min, box_x_max, box_y_max,
    // query_x_min, query_y_min, query_x_max, query_y_max
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [8*COORD_BITS-1:0]   s_axis_tdata,
    // union_ratio, query_ratio, overlaps, zero fill
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata
);
    localparam int PW = 2 * (COORD_BITS + 1);

    logic [MARGIN_W-1:0]  r_margin;
    logic                 en;
    logic                 e_vld, e_ovl, a_vld, a_ovl, d_vld, d_ovl;
    logic [COORD_BITS:0]  e_iw, e_ih, e_bw, e_bh, e_qw, e_qh;
    logic [PW-1:0]        a_inter, a_qarea;
    logic [PW:0]          a_union;
    logic [RATIO_W-1:0]   d_uratio, d_qratio;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_EXTENT_MARGIN) begin
            r_margin <= pwdata[MARGIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXTENT_MARGIN) ?
                    {{(DATA_W-MARGIN_W){1'b0}}, r_margin} : '0;

    // Advance the pipeline unless a result waits at the output
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    bpor_extent #(.COORD_BITS(COORD_BITS)) u_extent (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (s_axis_tvalid),
        .i_coords (s_axis_tdata),
        .i_margin (r_margin),
        .o_vld    (e_vld),
        .o_ovl    (e_ovl),
        .o_iw     (e_iw),
        .o_ih     (e_ih),
        .o_bw     (e_bw),
        .o_bh     (e_bh),
        .o_qw     (e_qw),
        .o_qh     (e_qh)
    );

    bpor_area #(.COORD_BITS(COORD_BITS)) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (e_vld),
        .i_ovl   (e_ovl),
        .i_iw    (e_iw),
        .i_ih    (e_ih),
        .i_bw    (e_bw),
        .i_bh    (e_bh),
        .i_qw    (e_qw),
        .i_qh    (e_qh),
        .o_vld   (a_vld),
        .o_ovl   (a_ovl),
        .o_inter (a_inter),
        .o_qarea (a_qarea),
        .o_union (a_union)
    );

    bpor_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_divider (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (a_vld),
        .i_ovl         (a_ovl),
        .i_inter       (a_inter),
        .i_qarea       (a_qarea),
        .i_union       (a_union),
        .o_vld         (d_vld),
        .o_ovl         (d_ovl),
        .o_union_ratio (d_uratio),
        .o_query_ratio (d_qratio)
    );

    assign m_axis_tvalid = d_vld;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, d_ovl, d_qratio, d_uratio};
endmodule

FILE: tb/box_pair_overlap_ratios_tb.sv
// ----------------------------------------------------------------------------
// box_pair_overlap_ratios_tb
// Self-checking bench for the box pair overlap ratio pipeline: streams box
// pairs under random valid/ready gaps, sweeps the extent margin over APB
// while idle, and checks each result against an exact integer predictor.
// ----------------------------------------------------------------------------
module box_pair_overlap_ratios_tb;
    import bpor_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_BITS_DEF;
    localparam int FB = RATIO_FRAC_BITS_DEF;
    localparam int LATENCY = 4 + FB + 1;

    typedef struct packed {
        logic signed [CW-1:0] qy1, qx1, qy0, qx0, by1, bx1, by0, bx0;
    } box_pair_t;

    typedef struct {
        logic [RATIO_W-1:0] union_ratio;
        logic [RATIO_W-1:0] query_ratio;
        logic               overlaps;
    } ratios_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [8*CW-1:0]    s_axis_tdata;   // bx0, by0, bx1, by1, qx0, qy0, qx1, qy1
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // union_ratio, query_ratio, overlaps, zero fill

    int  error_count;
    bit  sink_calm;

    box_pair_overlap_ratios DUT (.*);

    // Exact ratio predictor and in-order store of expected results
    class overlap_scoreboard;
        logic [7:0] margin;
        ratios_t    pending[$];

        function automatic logic [RATIO_W-1:0] frac(longint unsigned num,
                                                    longint unsigned den);
            logic [127:0] q;
            q = ({64'd0, num} << FB) / {64'd0, den};
            return q[RATIO_W-1:0];
        endfunction

        function void note_pair(box_pair_t p);
            ratios_t r;
            longint iw, ih, bw, bh, qw, qh, m;
            longint unsigned inter, barea, qarea;
            m  = longint'(margin);
            iw = longint'(p.bx1 < p.qx1 ? p.bx1 : p.qx1)
               - longint'(p.bx0 > p.qx0 ? p.bx0 : p.qx0) + m;
            ih = longint'(p.by1 < p.qy1 ? p.by1 : p.qy1)
               - longint'(p.by0 > p.qy0 ? p.by0 : p.qy0) + m;
            r = '{default: '0};
            if (iw > 0 && ih > 0) begin
                bw = longint'(p.bx1) - longint'(p.bx0) + m;
                bh = longint'(p.by1) - longint'(p.by0) + m;
                qw = longint'(p.qx1) - longint'(p.qx0) + m;
                qh = longint'(p.qy1) - longint'(p.qy0) + m;
                inter = iw * ih;
                barea = bw * bh;
                qarea = qw * qh;
                r.union_ratio = frac(inter, barea + qarea - inter);
                r.query_ratio = frac(inter, qarea);
                r.overlaps    = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function string check_result(logic [OUT_W-1:0] d);
            ratios_t e;
            if (pending.size() == 0) return "result with nothing pending";
            e = pending.pop_front();
            if (d[RATIO_W-1:0] !== e.union_ratio)
                return $sformatf("union_ratio %0d, want %0d", d[RATIO_W-1:0], e.union_ratio);
            if (d[2*RATIO_W-1:RATIO_W] !== e.query_ratio)
                return $sformatf("query_ratio %0d, want %0d",
                                 d[2*RATIO_W-1:RATIO_W], e.query_ratio);
            if (d[2*RATIO_W] !== e.overlaps)
                return $sformatf("overlaps %0b, want %0b", d[2*RATIO_W], e.overlaps);
            return "";
        endfunction
    endclass

    overlap_scoreboard ratios_sb;

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("box_pair_overlap_ratios_tb: errors");
        $finish;
    end

    // Drain side: random stalls except in calm stretches
    always @(posedge i_clk) begin
        string msg;
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            msg = ratios_sb.check_result(m_axis_tdata);
            if (msg != "") report_mismatch(msg);
        end
        m_axis_tready <= sink_calm || ($urandom_range(99) >= 26);
    end

    task automatic write_margin(logic [7:0] value);
        logic [DATA_W-1:0] rd;
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(REG_EXTENT_MARGIN) << 2; pwdata <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0;
        ratios_sb.margin = value;
        if (rd[7:0] !== value)
            report_mismatch($sformatf("margin readback %0d, want %0d", rd[7:0], value));
    endtask

    task automatic send_pair(box_pair_t p, bit calm);
        while (!calm && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.qy1, p.qx1, p.qy0, p.qx0, p.by1, p.bx1, p.by0, p.bx0};
        do @(posedge i_clk); while (!s_axis_tready);
        ratios_sb.note_pair(p);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (ratios_sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0:       return CW'($urandom);
            1:       return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mostly overlapping pairs: query near the box, sizes small
    function automatic box_pair_t rand_pair();
        box_pair_t p;
        logic signed [CW-1:0] c[8];
        if ($urandom_range(99) < 20) begin
            foreach (c[i]) c[i] = rand_coord();
        end else begin
            c[0] = CW'($signed($urandom_range(16000)) - 8000);
            c[1] = CW'($signed($urandom_range(16000)) - 8000);
            c[2] = c[0] + CW'($urandom_range(3000));
            c[3] = c[1] + CW'($urandom_range(3000));
            c[4] = c[0] + CW'($signed($urandom_range(3000)) - 1500);
            c[5] = c[1] + CW'($signed($urandom_range(3000)) - 1500);
            c[6] = c[4] + CW'($urandom_range(3000));
            c[7] = c[5] + CW'($urandom_range(3000));
        end
        {p.bx0, p.by0, p.bx1, p.by1, p.qx0, p.qy0, p.qx1, p.qy1} =
            {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
        return p;
    endfunction

    initial begin
        box_pair_t p;
        logic signed [CW-1:0] mx, mn;
        logic [7:0] margins[5] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd37};
        ratios_sb = new();
        ratios_sb.margin = '0;
        error_count = 0;
        sink_calm = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identical, disjoint, edge-touching, contained, inverted, extremes
        write_margin(8'd0);
        send_pair('{bx0: 0, by0: 0, bx1: 256, by1: 256, qx0: 0, qy0: 0, qx1: 256, qy1: 256}, 1);
        send_pair('{bx0: 0, by0: 0, bx1: 10, by1: 10, qx0: 20, qy0: 20, qx1: 30, qy1: 30}, 1);
        send_pair('{bx0: 0, by0: 0, bx1: 10, by1: 10, qx0: 10, qy0: 0, qx1: 20, qy1: 10}, 1);
        send_pair('{bx0: -100, by0: -100, bx1: 100, by1: 100,
                    qx0: -10, qy0: -10, qx1: 10, qy1: 10}, 1);
        send_pair('{bx0: -10, by0: -10, bx1: 10, by1: 10,
                    qx0: -100, qy0: -100, qx1: 100, qy1: 100}, 1);
        send_pair('{bx0: 10, by0: 10, bx1: 0, by1: 0, qx0: 0, qy0: 0, qx1: 10, qy1: 10}, 1);
        send_pair('{bx0: mn, by0: mn, bx1: mx, by1: mx, qx0: mn, qy0: mn, qx1: mx, qy1: mx}, 1);
        send_pair('{bx0: mx, by0: mx, bx1: mn, by1: mn, qx0: mn, qy0: mn, qx1: mx, qy1: mx}, 1);
        send_pair('{bx0: mn, by0: 0, bx1: mx, by1: 5, qx0: 0, qy0: mn, qx1: 5, qy1: mx}, 1);
        wait_drained();
        write_margin(8'd255);
        send_pair('{bx0: 0, by0: 0, bx1: 0, by1: 0, qx0: 0, qy0: 0, qx1: 0, qy1: 0}, 1);
        send_pair('{bx0: 0, by0: 0, bx1: 10, by1: 10, qx0: 200, qy0: 200, qx1: 300, qy1: 300}, 1);
        send_pair('{bx0: 0, by0: 0, bx1: 10, by1: 10, qx0: 265, qy0: 0, qx1: 300, qy1: 10}, 1);
        send_pair('{bx0: mn, by0: mn, bx1: mx, by1: mx, qx0: mn, qy0: mn, qx1: mx, qy1: mx}, 1);
        send_pair('{bx0: 0, by0: 0, bx1: -200, by1: -200, qx0: 0, qy0: 0, qx1: 5, qy1: 5}, 1);

        // Random phases over several margin settings; one phase without random gaps
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_margin(ph == 4 ? 8'($urandom) : margins[ph]);
            sink_calm = (ph == 2);
            for (int n = 0; n < 228; n++) begin
                p = rand_pair();
                send_pair(p, ph == 2);
                // sender holds off until the pipe is empty
                if (n == 100) wait_drained();
            end
        end
        sink_calm = 1'b0;
        wait_drained();

        if (error_count == 0) begin
            $display("box_pair_overlap_ratios_tb: clean");
        end else begin
            $display("box_pair_overlap_ratios_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bpor_pkg.sv
rtl/core/bpor_extent.sv
rtl/core/bpor_area.sv
rtl/core/bpor_divider.sv
rtl/core/box_pair_overlap_ratios.sv
tb/box_pair_overlap_ratios_tb.sv
